// ===== rtl/core/ihq_pkg.sv =====
// Shared types and constants for the indexed min-heap queue.
package ihq_pkg;

  localparam int CAPACITY  = 128;
  localparam int ADDR_W    = 7;
  localparam int COUNT_W   = 8;
  localparam int KEY_W     = 7;
  localparam int KEYS      = 128;
  localparam int PRIO_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 3'd0,
    CMD_BUILD  = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_DECKEY = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_BLD,
    S_BLD_LD,
    S_SD_RD,
    S_SD_CMP,
    S_SU_RD,
    S_SU_CMP,
    S_PLACE,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_DISPATCH,
    OP_BLD_RD,
    OP_LOAD_CUR,
    OP_SD_RD,
    OP_SD_STEP,
    OP_SU_RD,
    OP_SU_STEP,
    OP_PLACE,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } heap_ent_t;

  typedef struct packed {
    dp_op_t op;
  } dp_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic key_present;
    logic heap_empty;
    logic one_left;
    logic sd_leaf;
    logic sd_swap;
    logic su_top;
    logic su_swap;
    logic su_moved;
    logic bld_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/ihq_if.sv =====
// Valid/ready channel interfaces for command input and result output.
interface ihq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [6:0]  key;
  logic [31:0] priority_req;

  modport source (output valid, output command, output key, output priority_req,
                  input ready);
  modport sink (input valid, input command, input key, input priority_req,
                output ready);
endinterface

interface ihq_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  out_key;
  logic [31:0] out_priority;
  logic [1:0]  status;
  logic [7:0]  entry_total;

  modport source (output valid, output out_key, output out_priority, output status,
                  output entry_total, input ready);
  modport sink (input valid, input out_key, input out_priority, input status,
                input entry_total, output ready);
endinterface

// ===== rtl/core/ihq_datapath.sv =====
// Heap storage, position map, present bits and sift datapath.
module ihq_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ihq_pkg::dp_ctl_t        ctl,
  output ihq_pkg::dp_stat_t       stat,
  input  logic [2:0]              in_command,
  input  logic [6:0]              in_key,
  input  logic [31:0]             in_priority_req,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [6:0]              out_key,
  output logic [31:0]             out_priority,
  output logic [1:0]              out_status,
  output logic [7:0]              out_entry_total
);
  import ihq_pkg::*;

  heap_ent_t          heap_mem [CAPACITY];
  logic [ADDR_W-1:0]  map_mem  [KEYS];

  heap_ent_t          rd_a_r, rd_b_r;
  logic [ADDR_W-1:0]  map_rd_r;
  logic [ADDR_W-1:0]  rd_a_addr, rd_b_addr;

  logic               heap_we;
  logic [ADDR_W-1:0]  heap_waddr;
  heap_ent_t          heap_wdata;
  logic               map_we;
  logic [KEY_W-1:0]   map_waddr;
  logic [ADDR_W-1:0]  map_wdata;

  logic [CMD_W-1:0]   cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [PRIO_W-1:0]  prio_r;
  logic [COUNT_W-1:0] count_r;
  logic [KEYS-1:0]    present_r;
  logic [ADDR_W-1:0]  i_r;
  logic [ADDR_W-1:0]  b_r;
  heap_ent_t          cur_r;
  logic               moved_r;
  logic [STATUS_W-1:0] status_r;
  logic [KEY_W-1:0]   okey_r;
  logic [PRIO_W-1:0]  oprio_r;
  logic               out_valid_r;
  logic [KEY_W-1:0]   out_key_r;
  logic [PRIO_W-1:0]  out_prio_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0] out_total_r;

  logic [COUNT_W-1:0] left;
  logic [COUNT_W-1:0] right;
  logic               right_ok;
  logic               pick_right;
  heap_ent_t          child;
  logic [ADDR_W-1:0]  child_idx;
  logic [ADDR_W-1:0]  parent_idx;
  logic               full;

  assign left       = {i_r, 1'b1};
  assign right      = left + COUNT_W'(1);
  assign right_ok   = right < count_r;
  assign pick_right = right_ok && (rd_b_r.prio < rd_a_r.prio);
  assign child      = pick_right ? rd_b_r : rd_a_r;
  assign child_idx  = pick_right ? right[ADDR_W-1:0] : left[ADDR_W-1:0];
  assign parent_idx = (i_r - ADDR_W'(1)) >> 1;
  assign full       = count_r >= COUNT_W'(CAPACITY);

  assign stat.cmd         = cmd_r;
  assign stat.key_present = present_r[key_r];
  assign stat.heap_empty  = count_r == '0;
  assign stat.one_left    = count_r == COUNT_W'(1);
  assign stat.sd_leaf     = left >= count_r;
  assign stat.sd_swap     = cur_r.prio > child.prio;
  assign stat.su_top      = i_r == '0;
  assign stat.su_swap     = cur_r.prio < rd_a_r.prio;
  assign stat.su_moved    = moved_r;
  assign stat.bld_done    = b_r == '0;
  assign stat.out_free    = !out_valid_r || out_ready;

  always_comb begin
    rd_a_addr = '0;
    rd_b_addr = '0;
    case (ctl.op)
      OP_ACCEPT: begin
        rd_a_addr = '0;
        rd_b_addr = ADDR_W'(count_r - COUNT_W'(1));
      end
      OP_BLD_RD: rd_a_addr = b_r - ADDR_W'(1);
      OP_SD_RD: begin
        rd_a_addr = left[ADDR_W-1:0];
        rd_b_addr = right[ADDR_W-1:0];
      end
      OP_SU_RD: rd_a_addr = parent_idx;
      default: ;
    endcase
  end

  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = i_r;
    heap_wdata = cur_r;
    map_we     = 1'b0;
    map_waddr  = cur_r.key;
    map_wdata  = i_r;
    case (ctl.op)
      OP_DISPATCH: begin
        if (cmd_r == CMD_LOAD) begin
          heap_wdata = '{key: key_r, prio: prio_r};
          if (present_r[key_r]) begin
            heap_we    = 1'b1;
            heap_waddr = map_rd_r;
          end else if (!full) begin
            heap_we    = 1'b1;
            heap_waddr = count_r[ADDR_W-1:0];
            map_we     = 1'b1;
            map_waddr  = key_r;
            map_wdata  = count_r[ADDR_W-1:0];
          end
        end
      end
      OP_SD_STEP: begin
        heap_we = 1'b1;
        map_we  = 1'b1;
        if (stat.sd_swap) begin
          heap_wdata = child;
          map_waddr  = child.key;
        end
      end
      OP_SU_STEP: begin
        if (stat.su_swap) begin
          heap_we    = 1'b1;
          heap_wdata = rd_a_r;
          map_we     = 1'b1;
          map_waddr  = rd_a_r.key;
        end
      end
      OP_PLACE: begin
        heap_we = 1'b1;
        map_we  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    rd_a_r <= heap_mem[rd_a_addr];
    rd_b_r <= heap_mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rd_r <= map_mem[in_key];
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_ACCEPT: begin
        cmd_r  <= in_command;
        key_r  <= in_key;
        prio_r <= in_priority_req;
      end
      OP_DISPATCH: begin
        status_r <= ST_OK;
        okey_r   <= '0;
        oprio_r  <= '0;
        moved_r  <= 1'b0;
        case (cmd_r)
          CMD_LOAD: begin
            if (!present_r[key_r] && full) begin
              status_r <= ST_FULL;
            end
          end
          CMD_BUILD: b_r <= count_r[COUNT_W-1:1];
          CMD_DELETE: begin
            if (count_r == '0) begin
              status_r <= ST_EMPTY;
            end else begin
              okey_r  <= rd_a_r.key;
              oprio_r <= rd_a_r.prio;
              cur_r   <= rd_b_r;
              i_r     <= '0;
            end
          end
          CMD_DECKEY: begin
            if (!present_r[key_r]) begin
              status_r <= ST_ABSENT;
            end else begin
              cur_r <= '{key: key_r, prio: prio_r};
              i_r   <= map_rd_r;
            end
          end
          default: ;
        endcase
      end
      OP_BLD_RD: begin
        i_r <= b_r - ADDR_W'(1);
        b_r <= b_r - ADDR_W'(1);
      end
      OP_LOAD_CUR: cur_r <= rd_a_r;
      OP_SD_STEP: begin
        if (stat.sd_swap) begin
          i_r <= child_idx;
        end
      end
      OP_SU_STEP: begin
        if (stat.su_swap) begin
          i_r     <= parent_idx;
          moved_r <= 1'b1;
        end
      end
      OP_OUT: begin
        out_key_r    <= okey_r;
        out_prio_r   <= oprio_r;
        out_status_r <= status_r;
        out_total_r  <= count_r;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (ctl.op == OP_DISPATCH) begin
        case (cmd_r)
          CMD_LOAD: begin
            if (!present_r[key_r] && !full) begin
              present_r[key_r] <= 1'b1;
              count_r          <= count_r + COUNT_W'(1);
            end
          end
          CMD_DELETE: begin
            if (count_r != '0) begin
              present_r[rd_a_r.key] <= 1'b0;
              count_r               <= count_r - COUNT_W'(1);
            end
          end
          CMD_CLEAR: begin
            present_r <= '0;
            count_r   <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key         = out_key_r;
  assign out_priority    = out_prio_r;
  assign out_status      = out_status_r;
  assign out_entry_total = out_total_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_present_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(present_r) == int'(count_r))
    else $error("present bits disagree with entry count");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_DISPATCH && cmd_r == CMD_CLEAR) |=> (present_r == '0 && count_r == '0))
    else $error("clear left entries behind");

  a_sift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_SD_RD) |-> ({1'b0, i_r} < count_r))
    else $error("sift-down index outside heap");
`endif

endmodule

// ===== rtl/core/ihq_ctrl.sv =====
// Command sequencer: dispatch, build loop, sift-up and sift-down steps.
module ihq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ihq_pkg::dp_stat_t  stat,
  output ihq_pkg::dp_ctl_t   ctl
);
  import ihq_pkg::*;

  state_t state_r, state_nxt;
  logic   building;

  assign building = stat.cmd == CMD_BUILD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DISP;
      S_DISP: begin
        case (stat.cmd)
          CMD_BUILD:  state_nxt = S_BLD;
          CMD_DELETE: state_nxt = (stat.heap_empty || stat.one_left) ? S_OUT : S_SD_RD;
          CMD_DECKEY: state_nxt = stat.key_present ? S_SU_RD : S_OUT;
          default:    state_nxt = S_OUT;
        endcase
      end
      S_BLD:    state_nxt = stat.bld_done ? S_OUT : S_BLD_LD;
      S_BLD_LD: state_nxt = S_SD_RD;
      S_SD_RD: begin
        if (stat.sd_leaf) begin
          state_nxt = building ? S_BLD : S_OUT;
        end else begin
          state_nxt = S_SD_CMP;
        end
      end
      S_SD_CMP: begin
        if (stat.sd_swap) begin
          state_nxt = S_SD_RD;
        end else begin
          state_nxt = building ? S_BLD : S_OUT;
        end
      end
      S_SU_RD: begin
        if (stat.su_top) begin
          state_nxt = stat.su_moved ? S_PLACE : S_SD_RD;
        end else begin
          state_nxt = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        if (stat.su_swap) begin
          state_nxt = S_SU_RD;
        end else begin
          state_nxt = stat.su_moved ? S_PLACE : S_SD_RD;
        end
      end
      S_PLACE: state_nxt = S_OUT;
      S_OUT:   if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.op   = OP_NONE;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) ctl.op = OP_ACCEPT;
      end
      S_DISP:   ctl.op = OP_DISPATCH;
      S_BLD:    if (!stat.bld_done) ctl.op = OP_BLD_RD;
      S_BLD_LD: ctl.op = OP_LOAD_CUR;
      S_SD_RD:  ctl.op = stat.sd_leaf ? OP_PLACE : OP_SD_RD;
      S_SD_CMP: ctl.op = OP_SD_STEP;
      S_SU_RD:  if (!stat.su_top) ctl.op = OP_SU_RD;
      S_SU_CMP: ctl.op = OP_SU_STEP;
      S_PLACE:  ctl.op = OP_PLACE;
      S_OUT:    if (stat.out_free) ctl.op = OP_OUT;
      default:  ctl.op = OP_NONE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE))
    else $error("ready outside idle");

  a_accept_dispatches: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISP))
    else $error("accepted command not dispatched");

  a_out_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_OUT) |=> (state_r == S_IDLE))
    else $error("result transfer did not end the command");
`endif

endmodule

// ===== rtl/core/indexed_min_heap_queue_core.sv =====
// Indexed min-heap queue: one result per command; each sift level is a read state and a
// compare state over the heap memory's registered read, and build sifts down each interior
// node in turn. One command at a time: a new command is accepted only in idle. Synchronous
// active-low reset empties the heap and marks all keys absent at once; heap and map
// memories are not cleared.
module indexed_min_heap_queue_core (
  input logic        clk,
  input logic        rst_n,
  ihq_in_if.sink     in_ch,
  ihq_out_if.source  out_ch
);
  import ihq_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  ihq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  ihq_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_command      (in_ch.command),
    .in_key          (in_ch.key),
    .in_priority_req (in_ch.priority_req),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_key         (out_ch.out_key),
    .out_priority    (out_ch.out_priority),
    .out_status      (out_ch.status),
    .out_entry_total (out_ch.entry_total)
  );

endmodule

// ===== verif/ihq_tb_if.sv =====
`timescale 1ns / 100ps
// Testbench-side note: channel interfaces come from the RTL file ihq_if.sv.
package ihq_tb_pkg;
  import ihq_pkg::*;

  typedef struct packed {
    logic [2:0]  command;
    logic [6:0]  key;
    logic [31:0] prio;
  } heap_cmd_t;

  typedef struct packed {
    logic [6:0]  key;
    logic [31:0] prio;
    logic [1:0]  status;
    logic [7:0]  total;
  } heap_rsp_t;
endpackage

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for indexed_min_heap_queue_core: directed and random commands vs. a heap predictor.
module tb;
  import ihq_pkg::*;
  import ihq_tb_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  ihq_in_if  in_ch ();
  ihq_out_if out_ch ();

  indexed_min_heap_queue_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // predictor state
  logic [6:0]  hkey [CAPACITY];
  logic [31:0] hprio [CAPACITY];
  int          posn [KEYS];
  bit          held [KEYS];
  int          count;

  heap_rsp_t expected_q[$];
  int  mismatches = 0;
  int  n_sent = 0;
  int  n_recv = 0;
  int  n_full = 0;
  int  n_deleted = 0;
  longint cycles = 0;

  function automatic void swap_slots(input int a, input int b);
    logic [6:0]  tk;
    logic [31:0] tp;
    tk = hkey[a]; tp = hprio[a];
    hkey[a] = hkey[b]; hprio[a] = hprio[b];
    hkey[b] = tk; hprio[b] = tp;
    posn[hkey[a]] = a;
    posn[hkey[b]] = b;
  endfunction

  function automatic void sink_down(input int i);
    int l;
    int s;
    while (i < count) begin
      l = 2 * i + 1;
      if (l >= count) break;
      s = l;
      if (l + 1 < count && hprio[l + 1] < hprio[s]) s = l + 1;
      if (hprio[i] > hprio[s]) begin
        swap_slots(i, s);
        i = s;
      end else break;
    end
  endfunction

  function automatic bit float_up(input int i);
    int p;
    bit moved;
    moved = 1'b0;
    while (i > 0 && i < count) begin
      p = (i - 1) / 2;
      if (hprio[i] < hprio[p]) begin
        swap_slots(i, p);
        i = p;
        moved = 1'b1;
      end else break;
    end
    return moved;
  endfunction

  function automatic heap_rsp_t apply_command(input heap_cmd_t c);
    heap_rsp_t r;
    int last;
    r = '0;
    case (c.command)
      CMD_LOAD: begin
        if (held[c.key] && posn[c.key] < count) hprio[posn[c.key]] = c.prio;
        else if (count >= CAPACITY) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          hkey[count] = c.key;
          hprio[count] = c.prio;
          posn[c.key] = count;
          held[c.key] = 1'b1;
          count++;
        end
      end
      CMD_BUILD: for (int i = count / 2; i > 0; i--) sink_down(i - 1);
      CMD_DELETE: begin
        if (count == 0) r.status = ST_EMPTY;
        else begin
          last = count - 1;
          r.key = hkey[0];
          r.prio = hprio[0];
          held[hkey[0]] = 1'b0;
          count = last;
          n_deleted++;
          if (last > 0) begin
            hkey[0] = hkey[last];
            hprio[0] = hprio[last];
            posn[hkey[0]] = 0;
            sink_down(0);
          end
        end
      end
      CMD_DECKEY: begin
        if (!held[c.key] || posn[c.key] >= count) r.status = ST_ABSENT;
        else begin
          hprio[posn[c.key]] = c.prio;
          if (!float_up(posn[c.key])) sink_down(posn[c.key]);
        end
      end
      CMD_CLEAR: begin
        for (int k = 0; k < KEYS; k++) held[k] = 1'b0;
        count = 0;
      end
      default: ;
    endcase
    r.total = count[7:0];
    return r;
  endfunction

  // send one command; predict at the transfer; valid stays up for a zero gap
  task automatic send_command(input logic [2:0] cmd, input logic [6:0] key,
                              input logic [31:0] prio);
    heap_cmd_t c;
    int gap;
    gap = $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    c.command = cmd; c.key = key; c.prio = prio;
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.key <= key;
    in_ch.priority_req <= prio;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(apply_command(c));
    n_sent++;
  endtask

  function automatic logic [31:0] rand_prio();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return 32'h0;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // pick a key that is held when possible
  function automatic logic [6:0] held_key();
    if (count == 0) return 7'($urandom_range(0, 127));
    return hkey[$urandom_range(0, count - 1)];
  endfunction

  // result side: random stall, compare at each transfer
  initial begin
    heap_rsp_t got;
    heap_rsp_t exp;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got = {out_ch.out_key, out_ch.out_priority, out_ch.status, out_ch.entry_total};
      n_recv++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp = expected_q.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch #%0d: key exp %0d got %0d, prio exp %h got %h, ",
                      "status exp %0d got %0d, total exp %0d got %0d"},
                     n_recv, exp.key, got.key, exp.prio, got.prio, exp.status, got.status,
                     exp.total, got.total);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
      $display("** indexed_min_heap_queue_core: FAILED **");
      $finish;
    end
  end

  task automatic test_directed();
    send_command(CMD_DELETE, 7'd0, 32'd0);          // empty heap
    send_command(CMD_BUILD, 7'd0, 32'd0);           // build on empty
    send_command(CMD_CLEAR, 7'd0, 32'd0);
    send_command(CMD_DECKEY, 7'd5, 32'd1);          // absent key
    send_command(CMD_LOAD, 7'd127, 32'hFFFF_FFFF);
    send_command(CMD_LOAD, 7'd0, 32'd0);
    send_command(CMD_LOAD, 7'd85, 32'h5555_5555);
    send_command(CMD_LOAD, 7'd42, 32'hAAAA_AAAA);
    send_command(CMD_LOAD, 7'd85, 32'd7);           // overwrite in place
    send_command(CMD_LOAD, 7'd9, 32'd7);            // tie
    send_command(CMD_BUILD, 7'd0, 32'd0);
    send_command(CMD_DECKEY, 7'd127, 32'd1);        // sift up
    send_command(CMD_DECKEY, 7'd0, 32'hFFFF_FFFE);  // larger: sift down
    send_command(CMD_LOAD, 7'd3, 32'd2);            // load after build
    send_command(3'd5, 7'd1, 32'd1);
    send_command(3'd7, 7'd127, 32'hFFFF_FFFF);
    repeat (6) send_command(CMD_DELETE, 7'd0, 32'd0);
    send_command(CMD_DELETE, 7'd0, 32'd0);
  endtask

  // fill to capacity, load a present key while full, then drain in order
  task automatic test_full_heap();
    send_command(CMD_CLEAR, 7'd0, 32'd0);
    for (int k = 0; k < KEYS; k++) send_command(CMD_LOAD, k[6:0], rand_prio());
    send_command(CMD_LOAD, 7'd4, 32'd1);            // present key, full heap
    send_command(CMD_CLEAR, 7'd0, 32'd0);
    for (int k = 0; k < KEYS; k++) send_command(CMD_LOAD, k[6:0], $urandom);
    send_command(CMD_BUILD, 7'd0, 32'd0);
    for (int k = 0; k < 20; k++) send_command(CMD_DELETE, 7'd0, 32'd0);
    for (int k = 0; k < 21; k++) send_command(CMD_LOAD, 7'($urandom_range(0, 127)), $urandom);
    send_command(CMD_BUILD, 7'd0, 32'd0);
    while (count > 0) send_command(CMD_DELETE, 7'd0, 32'd0);
  endtask

  // mostly well-formed queue traffic with some noise
  task automatic test_random_traffic(input int n_items);
    int sel;
    for (int n = 0; n < n_items; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) send_command(CMD_LOAD, 7'($urandom_range(0, 127)), rand_prio());
      else if (sel < 42) send_command(CMD_BUILD, 7'($urandom_range(0, 127)), $urandom);
      else if (sel < 65) send_command(CMD_DELETE, 7'($urandom_range(0, 127)), $urandom);
      else if (sel < 88) send_command(CMD_DECKEY, held_key(), rand_prio());
      else if (sel < 92) send_command(CMD_DECKEY, 7'($urandom_range(0, 127)), $urandom);
      else if (sel < 95) send_command(CMD_CLEAR, 7'($urandom_range(0, 127)), $urandom);
      else send_command(3'($urandom_range(5, 7)), 7'($urandom_range(0, 127)), $urandom);
    end
    send_command(CMD_BUILD, 7'd0, 32'd0);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.key = '0;
    in_ch.priority_req = '0;
    count = 0;
    for (int k = 0; k < KEYS; k++) begin
      held[k] = 1'b0;
      posn[k] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_heap();
    test_random_traffic(750);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("ran %0d commands, %0d results, %0d deletes returned an entry, %0d full loads",
             n_sent, n_recv, n_deleted, n_full);
    if (mismatches == 0) $display("** indexed_min_heap_queue_core: PASSED **");
    else begin
      $display("%0d mismatches", mismatches);
      $display("** indexed_min_heap_queue_core: FAILED **");
    end
    $finish;
  end
endmodule
